### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gtpc_pkg.sv
// Shared types and constants of the tadpole pattern counter
package gtpc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_ENTRIES  = 16384;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VTX_W + 1;
	localparam int ENT_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W        = ENT_W + 1;
	localparam int RS_DEPTH     = MAX_VERTICES + 1;
	localparam int PROD_W       = 2 * CNT_W;
	localparam int TOTAL_W      = 64;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_COUNT = 1'b1;

	typedef struct packed {
		logic             op;
		logic [VTX_W-1:0] row_vertex;
		logic [VTX_W-1:0] neighbor;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] pattern_count;
		logic               overflow;
		logic               load_error;
	} out_item_t;

	// Per-vertex scratch word: multiplicity in the current row and row cost
	typedef struct packed {
		logic [CNT_W-1:0] mult;
		logic [CNT_W-1:0] cost;
	} work_t;

	// Requests to the graph store
	typedef struct packed {
		logic              rs_we;
		logic              rs_re;
		logic [VCNT_W-1:0] rs_addr;
		logic [CNT_W-1:0]  rs_wdata;
		logic              nb_we;
		logic              nb_re;
		logic [ENT_W-1:0]  nb_addr;
		logic [VTX_W-1:0]  nb_wdata;
	} store_req_t;

	// Requests to the scratch memory
	typedef struct packed {
		logic             we;
		logic             re;
		logic [VTX_W-1:0] addr;
		work_t            wdata;
	} work_req_t;

	typedef enum logic [5:0] {
		S_CLR, S_IDLE, S_FILL, S_LWR,
		S_XINIT, S_XTOP, S_XSPAN,
		S_SPA, S_SPB, S_SPC,
		S_P1RD, S_P1A, S_P1SPAN, S_P1SCAN, S_P1CHK, S_P1WR,
		S_P2RD, S_P2Y, S_P2YSP, S_P2YW, S_P2YE, S_P2ZL, S_P2Z, S_P2ZSP,
		S_P2ZW, S_P2ZE, S_P2WL, S_P2W, S_P2WM, S_P2WT, S_P2ADD,
		S_P3RD, S_P3CLR, S_DONE
	} state_t;

endpackage

### design/gtpc_store.sv
// Graph store: row start table and neighbor list memory
module gtpc_store (
	input  logic                          clk,
	input  gtpc_pkg::store_req_t          req,
	output logic [gtpc_pkg::CNT_W-1:0]    rs_rd,
	output logic [gtpc_pkg::VTX_W-1:0]    nb_rd
);
	import gtpc_pkg::*;

	logic [CNT_W-1:0] rs_mem [0:RS_DEPTH-1];
	logic [VTX_W-1:0] nb_mem [0:MAX_ENTRIES-1];
	logic [CNT_W-1:0] rs_rd_q;
	logic [VTX_W-1:0] nb_rd_q;

	// row start table, one write and one registered read
	always_ff @(posedge clk) begin
		if (req.rs_we)
			rs_mem[req.rs_addr] <= req.rs_wdata;
		if (req.rs_re)
			rs_rd_q <= rs_mem[req.rs_addr];
	end

	// neighbor list
	always_ff @(posedge clk) begin
		if (req.nb_we)
			nb_mem[req.nb_addr] <= req.nb_wdata;
		if (req.nb_re)
			nb_rd_q <= nb_mem[req.nb_addr];
	end

	assign rs_rd = rs_rd_q;
	assign nb_rd = nb_rd_q;
endmodule

### design/gtpc_wmem.sv
// Per-vertex scratch memory (multiplicity and cost)
module gtpc_wmem (
	input  logic                  clk,
	input  gtpc_pkg::work_req_t   req,
	output gtpc_pkg::work_t       rd
);
	import gtpc_pkg::*;

	work_t mem [0:MAX_VERTICES-1];
	work_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.addr] <= req.wdata;
		if (req.re)
			rd_q <= mem[req.addr];
	end

	assign rd = rd_q;
endmodule

### design/gtpc_seq.sv
// Sequencer: load handling, graph walk, shared multiplier and accumulator
module gtpc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gtpc_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gtpc_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gtpc_pkg::VCNT_W-1:0]   cfg_data,
	output gtpc_pkg::store_req_t          st_req,
	input  logic [gtpc_pkg::CNT_W-1:0]    rs_rd,
	input  logic [gtpc_pkg::VTX_W-1:0]    nb_rd,
	output gtpc_pkg::work_req_t           wk_req,
	input  gtpc_pkg::work_t               wk_rd
);
	import gtpc_pkg::*;

	state_t state_q, state_d, ret_q;

	logic [VCNT_W-1:0]  vc_q, vc_act, next_row_q, wp_q, x_q, spv_q;
	logic [VTX_W-1:0]   clr_q, r_q, nb_q, a_q, y_q, z_q, w_q;
	logic [CNT_W-1:0]   ent_q, lo_q, hi_q, xs_q, xe_q, i_q, j_q, je_q, k_q, ke_q, c_q;
	logic [CNT_W-1:0]   i_nx;
	logic               spe_q, err_q, ovf_q, zin_q, out_valid_q;
	logic [PROD_W-1:0]  s_q, ey_q, ez_q, mul_q, term_q, prod, ez_sel;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   sum;
	out_item_t          out_q;
	logic               in_acc, load_bad, i_last;
	logic [VCNT_W-1:0]  r_ext, spv_nx;

	assign vc_act  = (vc_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc_q;
	assign in_acc  = in_valid && in_ready;
	assign r_ext   = {1'b0, in_data.row_vertex};
	assign load_bad = (ent_q >= CNT_W'(MAX_ENTRIES)) ||
		(VCNT_W'(r_ext + VCNT_W'(1)) < next_row_q);
	assign i_nx    = CNT_W'(i_q + CNT_W'(1));
	assign i_last  = (i_nx == xe_q);
	assign spv_nx  = VCNT_W'(spv_q + VCNT_W'(1));
	assign prod    = PROD_W'(wk_rd.mult) * PROD_W'(wk_rd.cost);
	assign ez_sel  = (zin_q && (z_q != w_q)) ? ez_q : '0;
	assign sum     = {1'b0, total_q} + (TOTAL_W+1)'(term_q);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory requests
	always_comb begin
		state_d = state_q;
		st_req  = '0;
		wk_req  = '0;
		unique case (state_q)
			S_CLR: begin
				wk_req.we   = 1'b1;
				wk_req.addr = clr_q;
				if (clr_q == '1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					if (in_data.op == OP_COUNT)
						state_d = S_XINIT;
					else if (!load_bad)
						state_d = (r_ext >= next_row_q) ? S_FILL : S_LWR;
				end
			end
			S_FILL: begin
				st_req.rs_we    = 1'b1;
				st_req.rs_addr  = wp_q;
				st_req.rs_wdata = ent_q;
				if (wp_q == {1'b0, r_q})
					state_d = S_LWR;
			end
			S_LWR: begin
				st_req.nb_we    = 1'b1;
				st_req.nb_addr  = ent_q[ENT_W-1:0];
				st_req.nb_wdata = nb_q;
				state_d         = S_IDLE;
			end
			S_XINIT: state_d = S_XTOP;
			S_XTOP:  state_d = (x_q == vc_act) ? S_DONE : S_SPA;
			S_XSPAN: state_d = (lo_q == hi_q) ? S_XTOP : S_P1RD;
			S_SPA: begin
				st_req.rs_re   = 1'b1;
				st_req.rs_addr = spv_q;
				state_d        = (spv_q >= vc_act) ? ret_q : S_SPB;
			end
			S_SPB: begin
				st_req.rs_re   = 1'b1;
				st_req.rs_addr = spv_nx;
				state_d        = S_SPC;
			end
			S_SPC: state_d = ret_q;
			S_P1RD: begin
				st_req.nb_re   = 1'b1;
				st_req.nb_addr = i_q[ENT_W-1:0];
				state_d        = S_P1A;
			end
			S_P1A: state_d = S_SPA;
			S_P1SPAN: begin
				wk_req.re   = 1'b1;
				wk_req.addr = a_q;
				state_d     = S_P1SCAN;
			end
			S_P1SCAN: begin
				if (j_q == je_q) begin
					state_d = S_P1WR;
				end else begin
					st_req.nb_re   = 1'b1;
					st_req.nb_addr = j_q[ENT_W-1:0];
					state_d        = S_P1CHK;
				end
			end
			S_P1CHK: state_d = S_P1SCAN;
			S_P1WR: begin
				wk_req.we         = 1'b1;
				wk_req.addr       = a_q;
				wk_req.wdata.mult = CNT_W'(wk_rd.mult + CNT_W'(1));
				wk_req.wdata.cost = c_q;
				state_d           = i_last ? S_P2RD : S_P1RD;
			end
			S_P2RD: begin
				st_req.nb_re   = 1'b1;
				st_req.nb_addr = i_q[ENT_W-1:0];
				state_d        = S_P2Y;
			end
			S_P2Y: state_d = S_SPA;
			S_P2YSP: begin
				wk_req.re   = 1'b1;
				wk_req.addr = y_q;
				state_d     = S_P2YW;
			end
			S_P2YW: state_d = S_P2YE;
			S_P2YE: state_d = S_P2ZL;
			S_P2ZL: begin
				if (j_q == je_q) begin
					state_d = i_last ? S_P3RD : S_P2RD;
				end else begin
					st_req.nb_re   = 1'b1;
					st_req.nb_addr = j_q[ENT_W-1:0];
					state_d        = S_P2Z;
				end
			end
			S_P2Z: state_d = ({1'b0, nb_rd} == x_q) ? S_P2ZL : S_SPA;
			S_P2ZSP: begin
				wk_req.re   = 1'b1;
				wk_req.addr = z_q;
				state_d     = S_P2ZW;
			end
			S_P2ZW: state_d = S_P2ZE;
			S_P2ZE: state_d = S_P2WL;
			S_P2WL: begin
				if (k_q == ke_q) begin
					state_d = S_P2ZL;
				end else begin
					st_req.nb_re   = 1'b1;
					st_req.nb_addr = k_q[ENT_W-1:0];
					state_d        = S_P2W;
				end
			end
			S_P2W: begin
				if (nb_rd >= y_q) begin
					state_d = S_P2WL;
				end else begin
					wk_req.re   = 1'b1;
					wk_req.addr = nb_rd;
					state_d     = S_P2WM;
				end
			end
			S_P2WM:  state_d = (wk_rd.mult == '0) ? S_P2WL : S_P2WT;
			S_P2WT:  state_d = S_P2ADD;
			S_P2ADD: state_d = S_P2WL;
			S_P3RD: begin
				st_req.nb_re   = 1'b1;
				st_req.nb_addr = i_q[ENT_W-1:0];
				state_d        = S_P3CLR;
			end
			S_P3CLR: begin
				wk_req.we   = 1'b1;
				wk_req.addr = nb_rd;
				state_d     = i_last ? S_XTOP : S_P3RD;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers: config, load bookkeeping, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= VCNT_W'(MAX_VERTICES);
			ent_q       <= '0;
			next_row_q  <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				vc_q <= cfg_data;
			if (state_q == S_CLR)
				clr_q <= VTX_W'(clr_q + VTX_W'(1));
			if (in_acc && in_data.op == OP_LOAD && load_bad)
				err_q <= 1'b1;
			if (state_q == S_LWR) begin
				ent_q      <= CNT_W'(ent_q + CNT_W'(1));
				next_row_q <= VCNT_W'({1'b0, r_q} + VCNT_W'(1));
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				r_q  <= in_data.row_vertex;
				nb_q <= in_data.neighbor;
				wp_q <= next_row_q;
			end
			S_FILL: wp_q <= VCNT_W'(wp_q + VCNT_W'(1));
			S_XINIT: begin
				x_q     <= '0;
				total_q <= '0;
				ovf_q   <= 1'b0;
			end
			S_XTOP: begin
				spv_q <= x_q;
				ret_q <= S_XSPAN;
			end
			S_XSPAN: begin
				xs_q <= lo_q;
				xe_q <= hi_q;
				i_q  <= lo_q;
				s_q  <= '0;
				if (lo_q == hi_q)
					x_q <= VCNT_W'(x_q + VCNT_W'(1));
			end
			S_SPA: begin
				spe_q <= (spv_q >= next_row_q);
				if (spv_q >= vc_act) begin
					lo_q <= '0;
					hi_q <= '0;
				end
			end
			S_SPB: begin
				lo_q  <= spe_q ? ent_q : rs_rd;
				spe_q <= (spv_nx >= next_row_q);
			end
			S_SPC: hi_q <= spe_q ? ent_q : rs_rd;
			S_P1A: begin
				a_q   <= nb_rd;
				spv_q <= {1'b0, nb_rd};
				ret_q <= S_P1SPAN;
			end
			S_P1SPAN: begin
				j_q  <= lo_q;
				je_q <= hi_q;
				c_q  <= '0;
			end
			S_P1CHK: begin
				if ({1'b0, nb_rd} != x_q)
					c_q <= CNT_W'(c_q + CNT_W'(1));
				j_q <= CNT_W'(j_q + CNT_W'(1));
			end
			S_P1WR: begin
				s_q <= PROD_W'(s_q + PROD_W'(c_q));
				i_q <= i_last ? xs_q : i_nx;
			end
			S_P2Y: begin
				y_q   <= nb_rd;
				spv_q <= {1'b0, nb_rd};
				ret_q <= S_P2YSP;
			end
			S_P2YSP: begin
				j_q  <= lo_q;
				je_q <= hi_q;
			end
			S_P2YW: mul_q <= prod;
			S_P2YE: ey_q <= mul_q;
			S_P2ZL: begin
				if (j_q == je_q)
					i_q <= i_last ? xs_q : i_nx;
			end
			S_P2Z: begin
				z_q   <= nb_rd;
				spv_q <= {1'b0, nb_rd};
				ret_q <= S_P2ZSP;
				if ({1'b0, nb_rd} == x_q)
					j_q <= CNT_W'(j_q + CNT_W'(1));
			end
			S_P2ZSP: begin
				k_q  <= lo_q;
				ke_q <= hi_q;
			end
			S_P2ZW: begin
				mul_q <= prod;
				zin_q <= (wk_rd.mult != '0) && (z_q != y_q);
			end
			S_P2ZE: ez_q <= mul_q;
			S_P2WL: begin
				if (k_q == ke_q)
					j_q <= CNT_W'(j_q + CNT_W'(1));
			end
			S_P2W: begin
				w_q <= nb_rd;
				if (nb_rd >= y_q)
					k_q <= CNT_W'(k_q + CNT_W'(1));
			end
			S_P2WM: begin
				mul_q <= prod;
				if (wk_rd.mult == '0)
					k_q <= CNT_W'(k_q + CNT_W'(1));
			end
			S_P2WT: term_q <= PROD_W'(s_q - ey_q - mul_q - ez_sel);
			S_P2ADD: begin
				// saturate at the all-ones count
				if (sum[TOTAL_W]) begin
					total_q <= '1;
					ovf_q   <= 1'b1;
				end else begin
					total_q <= sum[TOTAL_W-1:0];
				end
				k_q <= CNT_W'(k_q + CNT_W'(1));
			end
			S_P3CLR: begin
				if (i_last)
					x_q <= VCNT_W'(x_q + VCNT_W'(1));
				else
					i_q <= i_nx;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.pattern_count <= total_q;
					out_q.overflow      <= ovf_q;
					out_q.load_error    <= err_q;
				end
			end
			default: ;
		endcase
	end
endmodule

### design/graph_tadpole_pattern_counter.sv
// Tadpole pattern counter: top level
//
// Input channel (in_valid/in_ready/in_data): op 0 stores one adjacency entry,
// rows in ascending vertex order; op 1 requests a count. A load to the current
// row writes its entry directly; a load that opens a new row first writes the
// row start of each row number passed since the previous row (all rows up to
// it on the first load). A count walks every row of x, the row of each
// neighbor y, of each neighbor z of y, and of each neighbor a of x, with row
// lookups for a, y and z, extra work for each matching w, and a clear of the
// scratch words of each entry of x's row; the memories have registered reads.
// One request at a time.
// Output channel (out_valid/out_ready/out_data): one result per count, held
// in an output register; the block accepts the next request while a result
// waits, and a finished count holds until the register is free.
// Config channel (cfg_valid/cfg_ready/cfg_data): vertex count, always ready;
// to be written while the block is idle, which the block does not enforce.
// After reset a clearing pass zeroes every word of the per-vertex scratch
// memory; in_ready stays low during it. Reset empties the graph.
module graph_tadpole_pattern_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gtpc_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gtpc_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gtpc_pkg::VCNT_W-1:0]   cfg_data
);
	import gtpc_pkg::*;

	store_req_t       st_req;
	work_req_t        wk_req;
	logic [CNT_W-1:0] rs_rd;
	logic [VTX_W-1:0] nb_rd;
	work_t            wk_rd;

	gtpc_store u_store (
		.clk   (clk),
		.req   (st_req),
		.rs_rd (rs_rd),
		.nb_rd (nb_rd)
	);

	gtpc_wmem u_wmem (
		.clk (clk),
		.req (wk_req),
		.rd  (wk_rd)
	);

	gtpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.st_req    (st_req),
		.rs_rd     (rs_rd),
		.nb_rd     (nb_rd),
		.wk_req    (wk_req),
		.wk_rd     (wk_rd)
	);
endmodule

### design/gtpc_checker.sv
// Port-level checks of the tadpole pattern counter, bound to the top level
`include "assert_macros.svh"

module gtpc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  gtpc_pkg::in_item_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  gtpc_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [gtpc_pkg::VCNT_W-1:0]   cfg_data
);
	import gtpc_pkg::*;

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "result dropped or changed while stalled")

	// overflow only with a saturated count
	`ASSERT_NOW(a_ovf_sat, clk, arst_n, out_valid && out_data.overflow,
		out_data.pattern_count == '1, "overflow flagged without saturated count")

	// a count request keeps the block busy for at least the next cycle
	`ASSERT_NEXT(a_count_busy, clk, arst_n,
		in_valid && in_ready && (in_data.op == OP_COUNT),
		!in_ready, "ready right after a count request")

	// a result only appears at the end of a busy count
	`ASSERT_NOW(a_out_from_busy, clk, arst_n, $rose(out_valid),
		$past(!in_ready), "result appeared while idle")
endmodule

bind graph_tadpole_pattern_counter gtpc_checker u_gtpc_checker (.*);
